// ===== rtl/core/tbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_pkg
// Shared constants, codes and types of the tile background fetcher.
// ----------------------------------------------------------------------------
package tbf_pkg;

    localparam int MEM_BYTES       = 8192;
    localparam int MEM_AW          = $clog2(MEM_BYTES);
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int FETCH_PIXELS    = 8;
    localparam int PIX_W           = 2;

    localparam logic [MEM_AW-1:0] MAP_BASE     = MEM_AW'(13'h1800);
    localparam logic [MEM_AW-1:0] MAP_HIGH_OFS = MEM_AW'(13'h0400);
    localparam logic [MEM_AW-1:0] SIGNED_BASE  = MEM_AW'(13'h1000);

    // request kinds carried in tuser
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_MAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_ENABLE  = 3'd5;

    typedef enum logic [1:0] {
        STEP_TILE = 2'd0,
        STEP_LOW  = 2'd1,
        STEP_HIGH = 2'd2,
        STEP_PUSH = 2'd3
    } t_fetch_step;

    typedef enum logic [1:0] {
        LOAD_NONE = 2'd0,
        LOAD_TILE = 2'd1,
        LOAD_LOW  = 2'd2,
        LOAD_HIGH = 2'd3
    } t_load;

    typedef struct packed {
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic       bg_map_high;
        logic       window_map_high;
        logic       signed_tile_data;
    } t_bg_cfg;

    typedef struct packed {
        logic       tick;
        logic       start;
        logic       window_select;
        logic [7:0] line_number;
        logic [7:0] window_line;
    } t_fetch_ctl;

    typedef struct packed {
        logic clear;
        logic pop;
        logic push;
    } t_queue_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/tbf_vram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_vram
// Video memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tbf_vram (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [tbf_pkg::MEM_AW-1:0] i_waddr,
    input  wire logic [7:0]                i_wdata,
    input  wire logic [tbf_pkg::MEM_AW-1:0] i_raddr,
    output logic      [7:0]                o_rdata
);

    logic [7:0] r_mem [tbf_pkg::MEM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/tbf_pixel_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_pixel_queue
// Shifting pixel queue: pops at the head, pushes eight colours after the tail.
// ----------------------------------------------------------------------------
module tbf_pixel_queue #(
    parameter int QUEUE_DEPTH = tbf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire tbf_pkg::t_queue_ctl                         i_ctl,
    input  wire logic [tbf_pkg::FETCH_PIXELS*tbf_pkg::PIX_W-1:0] i_push_pix,
    output logic                                             o_nonempty,
    output logic      [tbf_pkg::PIX_W-1:0]                   o_head,
    output logic                                             o_can_push
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int FP = tbf_pkg::FETCH_PIXELS;
    localparam int PW = tbf_pkg::PIX_W;

    logic [PW-1:0] r_q [QUEUE_DEPTH];
    logic [PW-1:0] n_q [QUEUE_DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          pop_go;
    logic [CW-1:0] cnt_after_pop;
    logic [CW:0]   tail_end;

    assign o_nonempty    = (r_cnt != '0);
    assign o_head        = r_q[0];
    assign pop_go        = i_ctl.pop && o_nonempty;
    assign cnt_after_pop = r_cnt - CW'(pop_go);
    assign o_can_push    = (cnt_after_pop <= CW'(QUEUE_DEPTH - FP));
    assign tail_end      = {1'b0, cnt_after_pop} + (CW+1)'(FP);

    always_comb begin
        logic [CW-1:0] off;
        off = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop_go) begin
                n_q[i] = (i < QUEUE_DEPTH - 1) ? r_q[(i + 1) % QUEUE_DEPTH] : '0;
            end else begin
                n_q[i] = r_q[i];
            end
            off = CW'(i) - cnt_after_pop;
            if (i_ctl.push && (CW'(i) >= cnt_after_pop)
                    && ((CW+1)'(i) < tail_end)) begin
                n_q[i] = i_push_pix[off[2:0]*PW +: PW];
            end
        end
    end

    always_comb begin
        if (i_ctl.clear) begin
            n_cnt = '0;
        end else if (i_ctl.push) begin
            n_cnt = cnt_after_pop + CW'(FP);
        end else begin
            n_cnt = cnt_after_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tbf_fetch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_fetch
// Tile fetch sequencer: map read, two plane reads, eight-pixel push.
// ----------------------------------------------------------------------------
module tbf_fetch (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire tbf_pkg::t_fetch_ctl                         i_ctl,
    input  wire tbf_pkg::t_bg_cfg                            i_cfg,
    input  wire logic                                        i_can_push,
    input  wire logic [7:0]                                  i_mem_q,
    output logic      [tbf_pkg::MEM_AW-1:0]                  o_raddr,
    output logic                                             o_push,
    output logic      [tbf_pkg::FETCH_PIXELS*tbf_pkg::PIX_W-1:0] o_push_pix
);

    localparam int AW = tbf_pkg::MEM_AW;
    localparam int FP = tbf_pkg::FETCH_PIXELS;
    localparam int PW = tbf_pkg::PIX_W;

    tbf_pkg::t_fetch_step r_step, n_step;
    tbf_pkg::t_load       r_load, n_load;
    logic       r_phase, n_phase;
    logic [4:0] r_col, n_col;
    logic       r_first, n_first;
    logic [7:0] r_line, r_wline;
    logic       r_win;
    logic [7:0] r_tile, r_plane_lo, r_plane_hi;

    logic [7:0]    bg_y;
    logic [2:0]    pix_row;
    logic [4:0]    tile_x, tile_y;
    logic          map_high;
    logic [AW-1:0] tile_map_addr;
    logic [AW-1:0] data_base;
    logic          step_go;

    assign bg_y    = r_line + i_cfg.scroll_y;
    assign pix_row = r_win ? r_wline[2:0] : bg_y[2:0];
    assign tile_y  = r_win ? r_wline[7:3] : bg_y[7:3];
    assign tile_x  = r_win ? r_col : (r_col + i_cfg.scroll_x[7:3]);
    assign step_go = i_ctl.tick && r_phase;

    assign map_high      = r_win ? i_cfg.window_map_high : i_cfg.bg_map_high;
    assign tile_map_addr = tbf_pkg::MAP_BASE
                         | (map_high ? tbf_pkg::MAP_HIGH_OFS : AW'(0))
                         | AW'({tile_y, tile_x});

    // signed ids sit around the middle of tile data, addresses wrap
    always_comb begin
        if (i_cfg.signed_tile_data) begin
            data_base = tbf_pkg::SIGNED_BASE
                      + AW'({{1{r_tile[7]}}, r_tile, 4'b0000})
                      + AW'({pix_row, 1'b0});
        end else begin
            data_base = AW'({r_tile, pix_row, 1'b0});
        end
    end

    // outputs: read address, load target, push
    always_comb begin
        o_raddr = tile_map_addr;
        n_load  = tbf_pkg::LOAD_NONE;
        o_push  = 1'b0;
        case (r_step)
            tbf_pkg::STEP_TILE: begin
                o_raddr = tile_map_addr;
                if (step_go) n_load = tbf_pkg::LOAD_TILE;
            end
            tbf_pkg::STEP_LOW: begin
                o_raddr = data_base;
                if (step_go) n_load = tbf_pkg::LOAD_LOW;
            end
            tbf_pkg::STEP_HIGH: begin
                o_raddr = data_base | AW'(1);
                if (step_go) n_load = tbf_pkg::LOAD_HIGH;
            end
            tbf_pkg::STEP_PUSH: begin
                o_push = step_go && i_can_push;
            end
            default: begin
                n_load = tbf_pkg::LOAD_NONE;
            end
        endcase
    end

    // leftmost pixel first
    always_comb begin
        for (int j = 0; j < FP; j++) begin
            o_push_pix[j*PW +: PW] = {r_plane_hi[FP-1-j], r_plane_lo[FP-1-j]};
        end
    end

    // next state
    always_comb begin
        n_step  = r_step;
        n_phase = r_phase;
        n_col   = r_col;
        n_first = r_first;
        if (i_ctl.start) begin
            n_step  = tbf_pkg::STEP_TILE;
            n_phase = 1'b0;
            n_col   = '0;
            n_first = 1'b1;
        end else if (i_ctl.tick) begin
            n_phase = !r_phase;
            if (r_phase) begin
                case (r_step)
                    tbf_pkg::STEP_TILE: n_step = tbf_pkg::STEP_LOW;
                    tbf_pkg::STEP_LOW:  n_step = tbf_pkg::STEP_HIGH;
                    tbf_pkg::STEP_HIGH: begin
                        // the first fetch of a line is dropped and redone
                        if (r_first) begin
                            n_first = 1'b0;
                            n_step  = tbf_pkg::STEP_TILE;
                        end else begin
                            n_step  = tbf_pkg::STEP_PUSH;
                        end
                    end
                    tbf_pkg::STEP_PUSH: begin
                        if (i_can_push) begin
                            n_col  = r_col + 5'd1;
                            n_step = tbf_pkg::STEP_TILE;
                        end
                    end
                    default: n_step = tbf_pkg::STEP_TILE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= tbf_pkg::STEP_TILE;
            r_load     <= tbf_pkg::LOAD_NONE;
            r_phase    <= 1'b0;
            r_col      <= '0;
            r_first    <= 1'b1;
            r_line     <= '0;
            r_wline    <= '0;
            r_win      <= 1'b0;
            r_tile     <= '0;
            r_plane_lo <= '0;
            r_plane_hi <= '0;
        end else begin
            r_step  <= n_step;
            r_load  <= n_load;
            r_phase <= n_phase;
            r_col   <= n_col;
            r_first <= n_first;
            if (i_ctl.start) begin
                r_line  <= i_ctl.line_number;
                r_wline <= i_ctl.window_line;
                r_win   <= i_ctl.window_select;
            end
            // read data lands in the cycle after the read was issued
            case (r_load)
                tbf_pkg::LOAD_TILE: r_tile     <= i_mem_q;
                tbf_pkg::LOAD_LOW:  r_plane_lo <= i_mem_q;
                tbf_pkg::LOAD_HIGH: r_plane_hi <= i_mem_q;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tile_background_fetcher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_background_fetcher_top
// Background and window tile fetcher with pixel queue and video memory.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns one
// result word for each: a word sits in the input register, where its memory
// write, queue pop and fetch step are applied, then moves to the output
// register. A fetch step issues one video memory read; the read byte is
// registered in the video memory, then loaded into the fetch register, always
// before the next fetch step needs it. Configuration writes are always
// accepted and should only be issued while the block is idle.
module tile_background_fetcher_top #(
    parameter int QUEUE_DEPTH = tbf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [12:0] mem_addr, [20:13] mem_data, [28:21] line_number,
    // [29] window_select, [37:30] window_line, [39:38] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] color_index, [7:2] zero
    output logic      [7:0]  m_axis_tdata,
    // [0] pixel_valid
    output logic             m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [tbf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int AW = tbf_pkg::MEM_AW;
    localparam int PW = tbf_pkg::PIX_W;

    // configuration
    tbf_pkg::t_bg_cfg r_cfg;
    logic             r_bg_enable;

    // input register
    logic        r_a_valid;
    logic [1:0]  r_a_req;
    logic [37:0] r_a_data;

    // output register
    logic          r_out_valid;
    logic          r_out_pix;
    logic [PW-1:0] r_out_color;

    logic [2:0] r_discard;

    logic a_fire;
    logic is_tick, is_start, is_write;

    tbf_pkg::t_fetch_ctl fetch_ctl;
    tbf_pkg::t_queue_ctl queue_ctl;
    logic                q_nonempty;
    logic [PW-1:0]       q_head;
    logic                q_can_push;
    logic                f_push;
    logic [tbf_pkg::FETCH_PIXELS*PW-1:0] f_push_pix;
    logic [AW-1:0]       raddr;
    logic [7:0]          mem_q;

    logic          n_pix;
    logic [PW-1:0] n_color;
    logic [2:0]    n_discard;

    assign a_fire        = r_a_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || a_fire;
    assign o_cfg_ready   = 1'b1;

    assign is_tick  = a_fire && (r_a_req == tbf_pkg::REQ_TICK);
    assign is_start = a_fire && (r_a_req == tbf_pkg::REQ_START);
    assign is_write = a_fire && (r_a_req == tbf_pkg::REQ_WRITE);

    assign fetch_ctl.tick          = is_tick;
    assign fetch_ctl.start         = is_start;
    assign fetch_ctl.line_number   = r_a_data[28:21];
    assign fetch_ctl.window_select = r_a_data[29];
    assign fetch_ctl.window_line   = r_a_data[37:30];

    assign queue_ctl.clear = is_start;
    assign queue_ctl.pop   = is_tick;
    assign queue_ctl.push  = f_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_bg_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tbf_pkg::CFG_SCROLL_X:  r_cfg.scroll_x         <= i_cfg_data;
                tbf_pkg::CFG_SCROLL_Y:  r_cfg.scroll_y         <= i_cfg_data;
                tbf_pkg::CFG_BG_MAP:    r_cfg.bg_map_high      <= i_cfg_data[0];
                tbf_pkg::CFG_WIN_MAP:   r_cfg.window_map_high  <= i_cfg_data[0];
                tbf_pkg::CFG_SIGNED:    r_cfg.signed_tile_data <= i_cfg_data[0];
                tbf_pkg::CFG_BG_ENABLE: r_bg_enable            <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_a_req  <= s_axis_tuser;
            r_a_data <= s_axis_tdata[37:0];
        end
    end

    // fine scroll drops the first scroll_x mod 8 pops of a line
    always_comb begin
        n_pix     = 1'b0;
        n_color   = '0;
        n_discard = r_discard;
        if (is_start) begin
            n_discard = '0;
        end else if (is_tick && q_nonempty) begin
            if (r_discard < r_cfg.scroll_x[2:0]) begin
                n_discard = r_discard + 3'd1;
            end else begin
                n_pix   = 1'b1;
                n_color = r_bg_enable ? q_head : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_discard   <= '0;
        end else begin
            r_discard <= n_discard;
            if (a_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (a_fire) begin
            r_out_pix   <= n_pix;
            r_out_color <= n_color;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_pix;
    assign m_axis_tdata  = {6'b000000, r_out_color};

    tbf_vram u_vram (
        .i_clk   (i_clk),
        .i_we    (is_write),
        .i_waddr (r_a_data[AW-1:0]),
        .i_wdata (r_a_data[20:13]),
        .i_raddr (raddr),
        .o_rdata (mem_q)
    );

    tbf_pixel_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (queue_ctl),
        .i_push_pix (f_push_pix),
        .o_nonempty (q_nonempty),
        .o_head     (q_head),
        .o_can_push (q_can_push)
    );

    tbf_fetch u_fetch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (fetch_ctl),
        .i_cfg      (r_cfg),
        .i_can_push (q_can_push),
        .i_mem_q    (mem_q),
        .o_raddr    (raddr),
        .o_push     (f_push),
        .o_push_pix (f_push_pix)
    );

endmodule
`default_nettype wire

// ===== dv/tile_background_fetcher_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_fetcher_top_tb
// Self-checking bench for the tile background fetcher. Tile maps hold only a
// few tile ids, and only two map rows and the data of those tiles are
// preloaded; line starts are picked so that every fetch reads defined bytes.
// A short directed run covers field extremes and odd request kinds. Random
// scan lines follow under several scroll, map and tile data settings. A cycle
// model predicts the pixel word for each request, and the output stream is
// checked in order while both sides stall.
// ----------------------------------------------------------------------------
module tile_background_fetcher_top_tb;

    localparam logic [1:0]  REQ_SPARE    = 2'd3;
    localparam logic [12:0] MAP_LO       = 13'h1800;
    localparam logic [12:0] MAP_HI       = 13'h1C00;
    localparam logic [12:0] SIGNED_DATA  = 13'h1000;
    localparam int          DRAIN_SETTLE = 4;
    // map rows that are preloaded
    localparam logic [4:0]  ROW_TOP      = 5'd0;
    localparam logic [4:0]  ROW_LOW      = 5'd17;
    // tile ids that the maps may hold
    localparam logic [7:0]  ID_ZERO      = 8'h00;
    localparam logic [7:0]  ID_MIN       = 8'h80;
    localparam logic [7:0]  ID_NEG1      = 8'hFF;

    typedef enum logic [1:0] {
        DO_REQ   = 2'd0,
        DO_CFG   = 2'd1,
        DO_DRAIN = 2'd2,
        DO_CALM  = 2'd3
    } t_stim_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  win_line;
        logic        win_sel;
        logic [7:0]  line;
        logic [7:0]  data;
        logic [12:0] addr;
    } t_fetch_req;

    typedef struct packed {
        logic       valid;
        logic [1:0] color;
    } t_pixel;

    typedef struct {
        t_stim_kind                    kind;
        t_fetch_req                    req;
        logic [tbf_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [7:0]                    reg_val;
    } t_stim;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [39:0]                   s_axis_tdata = '0;
    logic [1:0]                    s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;
    logic                          m_axis_tuser;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [tbf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]                    i_cfg_data = '0;

    tile_background_fetcher_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // fetcher model state
    logic [7:0]           cfg_scx = 8'd0;
    logic [7:0]           cfg_scy = 8'd0;
    logic                 cfg_bg_map = 1'b0;
    logic                 cfg_win_map = 1'b0;
    logic                 cfg_signed = 1'b0;
    logic                 cfg_bg_en = 1'b1;
    logic [7:0]           vram [0:8191];
    logic [1:0]           pixq [0:15] = '{default: 2'd0};
    int                   pixq_cnt = 0;
    tbf_pkg::t_fetch_step fetch_st = tbf_pkg::STEP_TILE;
    logic                 half_tick = 1'b0;
    logic [4:0]           tile_col = 5'd0;
    logic [7:0]           tile_id = 8'd0;
    logic [7:0]           lo_plane = 8'd0;
    logic [7:0]           hi_plane = 8'd0;
    logic                 throw_away = 1'b1;
    logic [2:0]           skip_cnt = 3'd0;
    logic [7:0]           line_q = 8'd0;
    logic [7:0]           winline_q = 8'd0;
    logic                 win_on = 1'b0;

    // scroll_y in force for the requests being generated
    logic [7:0] gen_scy = 8'd0;

    t_stim  pending_q [$];
    t_pixel pixel_expect_q [$];
    t_stim  cur;
    int     stim_items = 0;
    int     send_gap = 0;
    int     settle_cnt = 0;
    int     stall_left = 0;
    int     words_sent = 0;
    int     words_checked = 0;
    int     mismatches = 0;
    logic   calm = 1'b0;

    function automatic void apply_cfg(input logic [tbf_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [7:0] val);
        case (idx)
            tbf_pkg::CFG_SCROLL_X:  cfg_scx = val;
            tbf_pkg::CFG_SCROLL_Y:  cfg_scy = val;
            tbf_pkg::CFG_BG_MAP:    cfg_bg_map = val[0];
            tbf_pkg::CFG_WIN_MAP:   cfg_win_map = val[0];
            tbf_pkg::CFG_SIGNED:    cfg_signed = val[0];
            tbf_pkg::CFG_BG_ENABLE: cfg_bg_en = val[0];
            default: ;
        endcase
    endfunction

    function automatic t_pixel predict_pixel(input t_fetch_req r);
        t_pixel      res;
        logic [7:0]  bg_y;
        logic [2:0]  prow;
        logic [12:0] map_base;
        logic [12:0] pat_addr;
        logic [4:0]  tx;
        logic [4:0]  ty;
        int          k;
        res = '0;
        case (r.kind)
            tbf_pkg::REQ_WRITE: vram[r.addr] = r.data;
            tbf_pkg::REQ_START: begin
                for (k = 0; k < 16; k++) pixq[k] = 2'd0;
                pixq_cnt = 0;
                fetch_st = tbf_pkg::STEP_TILE;
                half_tick = 1'b0;
                tile_col = 5'd0;
                throw_away = 1'b1;
                skip_cnt = 3'd0;
                line_q = r.line;
                win_on = r.win_sel;
                winline_q = r.win_line;
            end
            tbf_pkg::REQ_TICK: begin
                if (pixq_cnt > 0) begin
                    // fine scroll eats the first scx%8 pops of a line
                    if (skip_cnt < cfg_scx[2:0]) begin
                        skip_cnt = skip_cnt + 3'd1;
                    end else begin
                        res.valid = 1'b1;
                        res.color = cfg_bg_en ? pixq[0] : 2'd0;
                    end
                    for (k = 0; k < 15; k++) pixq[k] = pixq[k+1];
                    pixq[15] = 2'd0;
                    pixq_cnt--;
                end
                half_tick = ~half_tick;
                if (!half_tick) begin
                    bg_y = line_q + cfg_scy;
                    prow = win_on ? winline_q[2:0] : bg_y[2:0];
                    if (win_on) begin
                        map_base = cfg_win_map ? MAP_HI : MAP_LO;
                        tx = tile_col;
                        ty = winline_q[7:3];
                    end else begin
                        map_base = cfg_bg_map ? MAP_HI : MAP_LO;
                        tx = tile_col + cfg_scx[7:3];
                        ty = bg_y[7:3];
                    end
                    // signed ids: sign-extended id times 16, wrapping in 13 bits
                    pat_addr = cfg_signed ? SIGNED_DATA + {tile_id[7], tile_id, 4'b0000}
                                          : {1'b0, tile_id, 4'b0000};
                    pat_addr = pat_addr + {9'd0, prow, 1'b0};
                    case (fetch_st)
                        tbf_pkg::STEP_TILE: begin
                            tile_id = vram[map_base + {3'd0, ty, tx}];
                            fetch_st = tbf_pkg::STEP_LOW;
                        end
                        tbf_pkg::STEP_LOW: begin
                            lo_plane = vram[pat_addr];
                            fetch_st = tbf_pkg::STEP_HIGH;
                        end
                        tbf_pkg::STEP_HIGH: begin
                            hi_plane = vram[pat_addr + 13'd1];
                            if (throw_away) begin
                                throw_away = 1'b0;
                                fetch_st = tbf_pkg::STEP_TILE;
                            end else begin
                                fetch_st = tbf_pkg::STEP_PUSH;
                            end
                        end
                        default: begin
                            if (pixq_cnt <= 8) begin
                                for (k = 0; k < 8; k++) begin
                                    pixq[pixq_cnt] = {hi_plane[7-k], lo_plane[7-k]};
                                    pixq_cnt++;
                                end
                                tile_col = tile_col + 5'd1;
                                fetch_st = tbf_pkg::STEP_TILE;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] pick_id();
        case ($urandom_range(0, 2))
            0: return ID_ZERO;
            1: return ID_MIN;
            default: return ID_NEG1;
        endcase
    endfunction

    function automatic t_fetch_req rand_req(input logic [1:0] kind);
        t_fetch_req r;
        r.kind = kind;
        r.addr = 13'($urandom);
        r.data = 8'($urandom);
        r.line = 8'($urandom_range(0, 153));
        r.win_sel = 1'($urandom);
        r.win_line = 8'($urandom_range(0, 143));
        return r;
    endfunction

    // keep map bytes to known tile ids and fetched rows to preloaded ones
    function automatic t_fetch_req legalize(input t_fetch_req r);
        logic [7:0] v;
        if (r.kind == tbf_pkg::REQ_WRITE && r.addr >= MAP_LO
                && !(r.data inside {ID_ZERO, ID_MIN, ID_NEG1})) begin
            r.data = pick_id();
        end
        if (r.kind == tbf_pkg::REQ_START) begin
            if (r.win_sel) begin
                if (!(r.win_line[7:3] inside {ROW_TOP, ROW_LOW})) begin
                    r.win_line = {(($urandom_range(0, 1) == 0) ? ROW_TOP : ROW_LOW),
                                  3'($urandom)};
                end
            end else begin
                v = r.line + gen_scy;
                if (!(v[7:3] inside {ROW_TOP, ROW_LOW})) begin
                    do begin
                        v = {(($urandom_range(0, 1) == 0) ? ROW_TOP : ROW_LOW),
                             3'($urandom)};
                        r.line = v - gen_scy;
                    end while (r.line > 8'd153);
                end
            end
        end
        return r;
    endfunction

    function automatic void add_req(input t_fetch_req r);
        pending_q.push_back('{kind: DO_REQ, req: legalize(r), reg_idx: '0, reg_val: '0});
        stim_items++;
    endfunction

    function automatic void add_mark(input t_stim_kind kind);
        pending_q.push_back('{kind: kind, req: '0, reg_idx: '0, reg_val: '0});
    endfunction

    function automatic void set_config(input logic [7:0] scx, input logic [7:0] scy,
                                       input logic bgm, input logic wm,
                                       input logic sgn, input logic en);
        // registers only change once the pipe has drained
        add_mark(DO_DRAIN);
        pending_q.push_back('{kind: DO_CFG, req: '0, reg_idx: tbf_pkg::CFG_SCROLL_X,
                              reg_val: scx});
        pending_q.push_back('{kind: DO_CFG, req: '0, reg_idx: tbf_pkg::CFG_SCROLL_Y,
                              reg_val: scy});
        pending_q.push_back('{kind: DO_CFG, req: '0, reg_idx: tbf_pkg::CFG_BG_MAP,
                              reg_val: {7'd0, bgm}});
        pending_q.push_back('{kind: DO_CFG, req: '0, reg_idx: tbf_pkg::CFG_WIN_MAP,
                              reg_val: {7'd0, wm}});
        pending_q.push_back('{kind: DO_CFG, req: '0, reg_idx: tbf_pkg::CFG_SIGNED,
                              reg_val: {7'd0, sgn}});
        pending_q.push_back('{kind: DO_CFG, req: '0, reg_idx: tbf_pkg::CFG_BG_ENABLE,
                              reg_val: {7'd0, en}});
        gen_scy = scy;
    endfunction

    // one scan line: start, then ticks with the odd memory write mixed in
    function automatic void add_line(input logic wide);
        t_fetch_req r;
        int         n;
        n = wide ? $urandom_range(270, 290) : $urandom_range(4, 60);
        r = rand_req(tbf_pkg::REQ_START);
        r.win_sel = ($urandom_range(0, 2) == 0);
        add_req(r);
        repeat (n) begin
            if ($urandom_range(0, 11) == 0) begin
                r = rand_req(tbf_pkg::REQ_WRITE);
                if ($urandom_range(0, 1) == 0) r.addr = MAP_LO + 13'($urandom_range(0, 2047));
                add_req(r);
            end
            add_req(rand_req(tbf_pkg::REQ_TICK));
        end
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_proc
        logic nv;
        logic nc;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nv = s_axis_tvalid;
            nc = i_cfg_valid;
            if (s_axis_tvalid && s_axis_tready) begin
                pixel_expect_q.push_back(predict_pixel(cur.req));
                words_sent <= words_sent + 1;
                nv = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_cfg(cur.reg_idx, cur.reg_val);
                nc = 1'b0;
            end
            if (!nv && !nc) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_q.size() > 0) begin
                    case (pending_q[0].kind)
                        DO_REQ: begin
                            cur = pending_q.pop_front();
                            nv = 1'b1;
                            s_axis_tdata <= {2'b00, cur.req.win_line, cur.req.win_sel,
                                             cur.req.line, cur.req.data, cur.req.addr};
                            s_axis_tuser <= cur.req.kind;
                            if (!calm && $urandom_range(0, 5) == 0)
                                send_gap = $urandom_range(1, 11);
                        end
                        DO_CFG: begin
                            cur = pending_q.pop_front();
                            nc = 1'b1;
                            i_cfg_index <= cur.reg_idx;
                            i_cfg_data <= cur.reg_val;
                        end
                        DO_DRAIN: begin
                            if (words_checked != words_sent) begin
                                settle_cnt = 0;
                            end else if (settle_cnt == DRAIN_SETTLE) begin
                                settle_cnt = 0;
                                void'(pending_q.pop_front());
                            end else begin
                                settle_cnt++;
                            end
                        end
                        default: begin
                            void'(pending_q.pop_front());
                            calm <= 1'b1;
                        end
                    endcase
                end
            end
            s_axis_tvalid <= nv;
            i_cfg_valid <= nc;
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_proc
        t_pixel want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (words_checked >= words_sent) begin
                    $display("%0t: unexpected word: pixel_valid %0d color_index %0d",
                             $time, m_axis_tuser, m_axis_tdata[1:0]);
                    mismatches++;
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (m_axis_tuser !== want.valid) begin
                        $display("%0t: word %0d pixel_valid: expected %0d, actual %0d",
                                 $time, words_checked, want.valid, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[1:0] !== want.color) begin
                        $display("%0t: word %0d color_index: expected %0d, actual %0d",
                                 $time, words_checked, want.color, m_axis_tdata[1:0]);
                        mismatches++;
                    end
                end
                words_checked <= words_checked + 1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_fetch_req  r;
        int          a;
        int          t;
        int          ph;
        int          target;
        logic [12:0] base;

        // line 153 plus this scroll lands on map row zero
        set_config(8'd3, 8'd103, 1'b0, 1'b0, 1'b0, 1'b1);
        // tile data of the map ids, in both unsigned and signed addressing
        for (t = 0; t < 4; t++) begin
            case (t)
                0: base = 13'h0000;
                1: base = 13'h1000;
                2: base = 13'h0800;
                default: base = 13'h0FF0;
            endcase
            for (a = 0; a < 16; a++) begin
                r = rand_req(tbf_pkg::REQ_WRITE);
                r.addr = base + 13'(a);
                add_req(r);
            end
        end
        // the two fetched rows of both maps
        for (t = 0; t < 4; t++) begin
            base = (t[0] ? MAP_HI : MAP_LO) + {3'd0, (t[1] ? ROW_LOW : ROW_TOP), 5'd0};
            for (a = 0; a < 32; a++) begin
                r = rand_req(tbf_pkg::REQ_WRITE);
                r.addr = base + 13'(a);
                r.data = pick_id();
                add_req(r);
            end
        end

        r = rand_req(tbf_pkg::REQ_WRITE);
        r.addr = 13'h0000;
        r.data = 8'hFF;
        add_req(r);
        r = rand_req(tbf_pkg::REQ_WRITE);
        r.addr = 13'h1FFF;
        r.data = 8'h00;
        add_req(r);
        add_req(rand_req(REQ_SPARE));
        // tick before any line start: empty queue
        add_req(rand_req(tbf_pkg::REQ_TICK));
        r = rand_req(tbf_pkg::REQ_START);
        r.line = 8'd153;
        r.win_sel = 1'b0;
        r.win_line = 8'd0;
        add_req(r);
        repeat (9) add_req(rand_req(tbf_pkg::REQ_TICK));
        add_req(rand_req(REQ_SPARE));
        repeat (9) add_req(rand_req(tbf_pkg::REQ_TICK));
        r = rand_req(tbf_pkg::REQ_START);
        r.line = 8'd0;
        r.win_sel = 1'b1;
        r.win_line = 8'd143;
        add_req(r);

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_config(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom), 1'b1);
                1: set_config(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
                2: set_config(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
                default: set_config(8'($urandom), 8'($urandom), 1'($urandom),
                                    1'($urandom), 1'($urandom), 1'b1);
            endcase
            if (ph == 4) add_mark(DO_CALM);
            // restart the line so the new scroll fetches preloaded rows
            add_req(rand_req(tbf_pkg::REQ_START));
            target = stim_items + 30;
            if (ph == 1) add_line(1'b1);
            while (stim_items < target) begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 6)) add_req(rand_req(2'($urandom_range(0, 3))));
                end else begin
                    add_line(1'b0);
                end
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid || i_cfg_valid ||
               words_checked != words_sent)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
